// ===== hdl/sorted_id_set_with_marks_assert.svh =====
// assertion macros for the sorted id set block
// used by sorted_id_set_with_marks.sv; expects clk and rst_n in scope
`ifndef SORTED_ID_SET_WITH_MARKS_ASSERT_SVH
`define SORTED_ID_SET_WITH_MARKS_ASSERT_SVH

// same-cycle implication
`define SIS_ASSERT_IMP(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication
`define SIS_ASSERT_NXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== hdl/sis_pkg.sv =====
// shared types and constants for the sorted id set block
// no dependencies
package sis_pkg;

    localparam int DEPTH  = 64;
    localparam int ID_W   = 16;
    localparam int IDX_W  = $clog2(DEPTH);
    localparam int CNT_W  = $clog2(DEPTH + 1);
    localparam int POS_W  = 6;
    localparam int RANK_W = 6;

    localparam logic [1:0] OP_INS_MAIN = 2'd0;
    localparam logic [1:0] OP_INS_MARK = 2'd1;
    localparam logic [1:0] OP_LOOKUP   = 2'd2;
    localparam logic [1:0] OP_READ     = 2'd3;

    localparam logic [1:0] ST_OK    = 2'd0;
    localparam logic [1:0] ST_DUP   = 2'd1;
    localparam logic [1:0] ST_FULL  = 2'd2;
    localparam logic [1:0] ST_RANGE = 2'd3;

    typedef logic [ID_W-1:0] id_t;
    typedef logic [DEPTH-1:0][ID_W-1:0] entry_vec_t;

    typedef struct packed {
        id_t  key;
        logic wr_en;
    } cell_bus_t;

    typedef struct packed {
        logic lt;
        logic eq;
    } cell_flags_t;

endpackage

// ===== hdl/sis_cell.sv =====
// one compare-and-shift cell: holds a table entry and its compare flags
// depends on sis_pkg
module sis_cell (
    input  logic                 clk,
    input  sis_pkg::cell_bus_t   bus,
    input  logic                 valid,
    input  sis_pkg::id_t         shift_in,
    input  logic                 lt_prev,
    output sis_pkg::id_t         entry,
    output sis_pkg::cell_flags_t flags
);

    sis_pkg::id_t         entry_reg;
    sis_pkg::id_t         entry_next;
    sis_pkg::cell_flags_t flags_reg;
    sis_pkg::cell_flags_t flags_next;

    always_comb
    begin
        flags_next.lt = valid && (entry_reg < bus.key);
        flags_next.eq = valid && (entry_reg == bus.key);
        entry_next    = entry_reg;
        if (bus.wr_en && !flags_reg.lt)
        begin
            entry_next = lt_prev ? bus.key : shift_in;
            if (lt_prev)
            begin
                entry_next = bus.key;
            end
            else
            begin
                entry_next = shift_in;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        entry_reg <= entry_next;
        flags_reg <= flags_next;
    end

    assign entry = entry_reg;
    assign flags = flags_reg;

endmodule

// ===== hdl/sis_chain.sv =====
// row of compare-and-shift cells forming one sorted table
// depends on sis_pkg and sis_cell
module sis_chain (
    input  logic                        clk,
    input  sis_pkg::cell_bus_t          bus,
    input  logic [sis_pkg::DEPTH-1:0]   valid,
    output sis_pkg::entry_vec_t         entries,
    output logic [sis_pkg::DEPTH-1:0]   lt,
    output logic [sis_pkg::DEPTH-1:0]   eq
);

    sis_pkg::cell_flags_t flags [sis_pkg::DEPTH];

    for (genvar k = 0; k < sis_pkg::DEPTH; k++)
    begin : g_cell
        sis_pkg::id_t shift_in;
        logic         lt_prev;

        if (k == 0)
        begin : g_head
            // head cell takes the key whenever it does not keep its entry
            assign shift_in = '0;
            assign lt_prev  = 1'b1;
        end
        else
        begin : g_body
            assign shift_in = entries[k-1];
            assign lt_prev  = lt[k-1];
        end

        sis_cell u_cell (
            .clk      (clk),
            .bus      (bus),
            .valid    (valid[k]),
            .shift_in (shift_in),
            .lt_prev  (lt_prev),
            .entry    (entries[k]),
            .flags    (flags[k])
        );

        assign lt[k] = flags[k].lt;
        assign eq[k] = flags[k].eq;
    end

endmodule

// ===== hdl/sorted_id_set_with_marks.sv =====
// sorted id set with marks: each transaction steps through the states read (reads only),
// compare and update, then done, which holds it until the output register is free; a read out
// of range goes from read straight to done; a new transaction is taken only in idle, after the
// last one has left done, and is taken while a result waits; reset clears both fill counts and
// the handshake state; table contents are kept
// depends on sis_pkg, sis_chain and sorted_id_set_with_marks_assert.svh
`include "sorted_id_set_with_marks_assert.svh"

module sorted_id_set_with_marks (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       in_valid,
    output logic                       in_ready,
    input  logic [1:0]                 opcode,
    input  logic [sis_pkg::ID_W-1:0]   item_id,
    input  logic [sis_pkg::POS_W-1:0]  position,
    output logic                       out_valid,
    input  logic                       out_ready,
    output logic [1:0]                 status,
    output logic                       found,
    output logic [sis_pkg::RANK_W-1:0] rank,
    output logic [sis_pkg::ID_W-1:0]   id_out,
    output logic                       marked,
    output logic [sis_pkg::CNT_W-1:0]  main_count
);

    typedef enum logic [2:0] {
        S_IDLE,
        S_READ,
        S_CMP,
        S_UPD,
        S_DONE
    } state_t;

    state_t                     state_reg, state_next;
    logic [1:0]                 op_reg, op_next;
    sis_pkg::id_t               key_reg, key_next;
    logic [sis_pkg::POS_W-1:0]  pos_reg, pos_next;
    logic [sis_pkg::CNT_W-1:0]  main_used_reg, main_used_next;
    logic [sis_pkg::CNT_W-1:0]  mark_used_reg, mark_used_next;
    logic [1:0]                 res_status_reg, res_status_next;
    logic                       res_found_reg, res_found_next;
    logic [sis_pkg::RANK_W-1:0] res_rank_reg, res_rank_next;
    sis_pkg::id_t               res_id_reg, res_id_next;
    logic                       res_marked_reg, res_marked_next;
    logic                       out_valid_reg, out_valid_next;
    logic [1:0]                 out_status_reg, out_status_next;
    logic                       out_found_reg, out_found_next;
    logic [sis_pkg::RANK_W-1:0] out_rank_reg, out_rank_next;
    sis_pkg::id_t               out_id_reg, out_id_next;
    logic                       out_marked_reg, out_marked_next;
    logic [sis_pkg::CNT_W-1:0]  out_count_reg, out_count_next;

    sis_pkg::cell_bus_t         main_bus, mark_bus;
    logic [sis_pkg::DEPTH-1:0]  main_valid, mark_valid;
    logic [sis_pkg::DEPTH-1:0]  main_lt, main_eq, mark_lt, mark_eq;
    sis_pkg::entry_vec_t        main_entries, mark_entries;

    logic                       main_dup, mark_dup, mark_all_lt, mark_rule;
    logic [sis_pkg::IDX_W-1:0]  hit_idx;
    logic                       in_fire, out_free;

    always_comb
    begin
        for (int k = 0; k < sis_pkg::DEPTH; k++)
        begin
            main_valid[k] = sis_pkg::CNT_W'(k) < main_used_reg;
            mark_valid[k] = sis_pkg::CNT_W'(k) < mark_used_reg;
        end
    end

    always_comb
    begin
        hit_idx = '0;
        for (int k = 0; k < sis_pkg::DEPTH; k++)
        begin
            if (main_eq[k])
            begin
                hit_idx = hit_idx | sis_pkg::IDX_W'(k);
            end
        end
    end

    assign main_dup    = |main_eq;
    assign mark_dup    = |mark_eq;
    assign mark_all_lt = &(mark_lt | ~mark_valid);
    assign mark_rule   = (mark_used_reg != '0) && (mark_dup || mark_all_lt);

    assign in_fire  = in_valid && in_ready;
    assign out_free = !out_valid_reg || out_ready;

    always_comb
    begin
        main_bus.key   = key_reg;
        main_bus.wr_en = (state_reg == S_UPD) && (op_reg == sis_pkg::OP_INS_MAIN)
                         && !main_dup && (main_used_reg != sis_pkg::CNT_W'(sis_pkg::DEPTH));
        mark_bus.key   = key_reg;
        mark_bus.wr_en = (state_reg == S_UPD) && (op_reg == sis_pkg::OP_INS_MARK)
                         && !mark_dup && (mark_used_reg != sis_pkg::CNT_W'(sis_pkg::DEPTH));
    end

    sis_chain u_main (
        .clk     (clk),
        .bus     (main_bus),
        .valid   (main_valid),
        .entries (main_entries),
        .lt      (main_lt),
        .eq      (main_eq)
    );

    sis_chain u_mark (
        .clk     (clk),
        .bus     (mark_bus),
        .valid   (mark_valid),
        .entries (mark_entries),
        .lt      (mark_lt),
        .eq      (mark_eq)
    );

    always_comb
    begin
        state_next      = state_reg;
        op_next         = op_reg;
        key_next        = key_reg;
        pos_next        = pos_reg;
        main_used_next  = main_used_reg;
        mark_used_next  = mark_used_reg;
        res_status_next = res_status_reg;
        res_found_next  = res_found_reg;
        res_rank_next   = res_rank_reg;
        res_id_next     = res_id_reg;
        res_marked_next = res_marked_reg;
        out_valid_next  = out_valid_reg;
        out_status_next = out_status_reg;
        out_found_next  = out_found_reg;
        out_rank_next   = out_rank_reg;
        out_id_next     = out_id_reg;
        out_marked_next = out_marked_reg;
        out_count_next  = out_count_reg;

        if (out_valid_reg && out_ready)
        begin
            out_valid_next = 1'b0;
        end

        case (state_reg)
            S_IDLE:
            begin
                if (in_fire)
                begin
                    op_next         = opcode;
                    key_next        = item_id;
                    pos_next        = position;
                    res_status_next = sis_pkg::ST_OK;
                    res_found_next  = 1'b0;
                    res_rank_next   = '0;
                    res_id_next     = '0;
                    res_marked_next = 1'b0;
                    state_next      = (opcode == sis_pkg::OP_READ) ? S_READ : S_CMP;
                end
            end
            S_READ:
            begin
                if ({1'b0, pos_reg} < main_used_reg)
                begin
                    key_next   = main_entries[pos_reg];
                    state_next = S_CMP;
                end
                else
                begin
                    res_status_next = sis_pkg::ST_RANGE;
                    state_next      = S_DONE;
                end
            end
            S_CMP:
            begin
                state_next = S_UPD;
            end
            S_UPD:
            begin
                case (op_reg)
                    sis_pkg::OP_INS_MAIN:
                    begin
                        if (main_dup)
                        begin
                            res_status_next = sis_pkg::ST_DUP;
                        end
                        else if (main_used_reg == sis_pkg::CNT_W'(sis_pkg::DEPTH))
                        begin
                            res_status_next = sis_pkg::ST_FULL;
                        end
                        else
                        begin
                            main_used_next = main_used_reg + 1'b1;
                        end
                    end
                    sis_pkg::OP_INS_MARK:
                    begin
                        if (mark_dup)
                        begin
                            res_status_next = sis_pkg::ST_DUP;
                        end
                        else if (mark_used_reg == sis_pkg::CNT_W'(sis_pkg::DEPTH))
                        begin
                            res_status_next = sis_pkg::ST_FULL;
                        end
                        else
                        begin
                            mark_used_next = mark_used_reg + 1'b1;
                        end
                    end
                    sis_pkg::OP_LOOKUP:
                    begin
                        res_found_next  = main_dup;
                        res_rank_next   = sis_pkg::RANK_W'(hit_idx);
                        res_marked_next = mark_rule;
                    end
                    default:
                    begin
                        res_id_next     = key_reg;
                        res_marked_next = mark_rule;
                    end
                endcase
                state_next = S_DONE;
            end
            S_DONE:
            begin
                if (out_free)
                begin
                    out_valid_next  = 1'b1;
                    out_status_next = res_status_reg;
                    out_found_next  = res_found_reg;
                    out_rank_next   = res_rank_reg;
                    out_id_next     = res_id_reg;
                    out_marked_next = res_marked_reg;
                    out_count_next  = main_used_reg;
                    state_next      = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= S_IDLE;
            main_used_reg  <= '0;
            mark_used_reg  <= '0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            state_reg      <= state_next;
            main_used_reg  <= main_used_next;
            mark_used_reg  <= mark_used_next;
            out_valid_reg  <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        op_reg         <= op_next;
        key_reg        <= key_next;
        pos_reg        <= pos_next;
        res_status_reg <= res_status_next;
        res_found_reg  <= res_found_next;
        res_rank_reg   <= res_rank_next;
        res_id_reg     <= res_id_next;
        res_marked_reg <= res_marked_next;
        out_status_reg <= out_status_next;
        out_found_reg  <= out_found_next;
        out_rank_reg   <= out_rank_next;
        out_id_reg     <= out_id_next;
        out_marked_reg <= out_marked_next;
        out_count_reg  <= out_count_next;
    end

    assign in_ready   = (state_reg == S_IDLE);
    assign out_valid  = out_valid_reg;
    assign status     = out_status_reg;
    assign found      = out_found_reg;
    assign rank       = out_rank_reg;
    assign id_out     = out_id_reg;
    assign marked     = out_marked_reg;
    assign main_count = out_count_reg;

    `SIS_ASSERT_IMP(a_count_bound, 1'b1, main_used_reg <= sis_pkg::CNT_W'(sis_pkg::DEPTH), "main count above depth")
    `SIS_ASSERT_NXT(a_busy_after_accept, in_fire, !in_ready, "transaction accepted while busy")
    `SIS_ASSERT_IMP(a_range_zero, out_valid && (status == sis_pkg::ST_RANGE), (id_out == '0) && !marked, "out of range result not cleared")
    `SIS_ASSERT_NXT(a_count_step, main_used_reg != main_used_next, main_used_reg == $past(main_used_reg) + 1'b1, "main count moved by more than one")

endmodule
